[sv/hsvrgb_pkg.sv]
package hsvrgb_pkg;

  typedef struct packed {
    logic [8:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;
  } hsv_word_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
  } rgb_word_t;

  // hue sectors, 60 degrees each
  localparam logic [2:0] SEC_R_G = 3'd0;
  localparam logic [2:0] SEC_G_R = 3'd1;
  localparam logic [2:0] SEC_G_B = 3'd2;
  localparam logic [2:0] SEC_B_G = 3'd3;
  localparam logic [2:0] SEC_B_R = 3'd4;
  localparam logic [2:0] SEC_R_B = 3'd5;

  localparam logic [8:0] HUE_WRAP = 9'd360;
  localparam logic [8:0] HUE_60   = 9'd60;
  localparam logic [8:0] HUE_120  = 9'd120;
  localparam logic [8:0] HUE_180  = 9'd180;
  localparam logic [8:0] HUE_240  = 9'd240;
  localparam logic [8:0] HUE_300  = 9'd300;

  // numerator width: 60*255*255 < 2**22
  localparam int unsigned NUM_W = 22;
  localparam logic [NUM_W-1:0] DIV_DEN   = 22'd15300;
  // floor(2**32 / 15300); estimate is low by at most one
  localparam logic [18:0]      DIV_RECIP = 19'd280716;
  localparam int unsigned      PROD_W    = NUM_W + 19;

endpackage

[sv/hsvrgb_div.sv]
module hsvrgb_div
  import hsvrgb_pkg::*;
(
  input  logic             clk,
  input  logic             en_a,
  input  logic             en_b,
  input  logic [NUM_W-1:0] num,
  output logic [7:0]       quo
);

  logic [PROD_W-1:0] prod_r;
  logic [NUM_W-1:0]  num_r;
  logic [7:0]        quo_r;
  logic [7:0]        q_est;
  logic [NUM_W-1:0]  q_mul;
  logic [NUM_W-1:0]  rem;
  logic [7:0]        quo_nxt;

  // reciprocal multiply; quotient sits in bits 39:32
  always_ff @(posedge clk) begin
    if (en_a) begin
      prod_r <= PROD_W'(num) * PROD_W'(DIV_RECIP);
      num_r  <= num;
    end
  end

  always_comb begin
    q_est   = prod_r[39:32];
    q_mul   = NUM_W'(q_est) * DIV_DEN;
    rem     = num_r - q_mul;
    quo_nxt = (rem >= DIV_DEN) ? q_est + 8'd1 : q_est;
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      quo_r <= quo_nxt;
    end
  end

  assign quo = quo_r;

endmodule

[sv/hsv_to_rgb_convert_core.sv]
// HSV to RGB pixel converter.
// Input channel: in_valid / in_stall / in_word (hue 0..511 degrees, reduced modulo 360, saturation
// and brightness as n/255). Output channel: out_valid / out_stall / out_word
// (8-bit red, green, blue, truncated toward zero).
// A word is taken at a clock edge with valid high and stall low.
// Throughput: one pixel per clock when the receiver does not stall.
// Stages: hue sector and ramp slope with v*s; base, chroma and ramp products;
// per-channel sums; reciprocal multiply; quotient correction into the output
// register. Each stage carries a valid bit and refills as soon as the stage
// below moves, so bubbles are squeezed out.
// When out_stall is held the output word holds; upstream stages keep filling
// until the pipe is full, then in_stall rises.
// Synchronous reset (rst_n low) empties the pipe; out_valid goes low.
module hsv_to_rgb_convert_core
  import hsvrgb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  hsv_word_t in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output rgb_word_t out_word
);

  localparam int unsigned N_ST = 5;

  logic [N_ST-1:0] vld_r;
  logic [N_ST-1:0] go;

  // stage 1
  logic [15:0] vs_r;
  logic [7:0]  v1_r;
  logic [2:0]  sec1_r;
  logic [5:0]  k1_r;
  // stage 2
  logic [NUM_W-1:0] base_r;
  logic [NUM_W-1:0] chroma_r;
  logic [NUM_W-1:0] ramp_r;
  logic [2:0]       sec2_r;
  // stage 3
  logic [NUM_W-1:0] num_r [3];

  logic [8:0]       h_red;
  logic [8:0]       hm;
  logic [6:0]       k_w;
  logic [2:0]       sec_nxt;
  logic [5:0]       k_nxt;
  logic [15:0]      vns;
  logic [NUM_W-1:0] num_nxt [3];
  logic [7:0]       quo [3];

  always_comb begin
    go[N_ST-1] = !vld_r[N_ST-1] || !out_stall;
    for (int i = N_ST - 2; i >= 0; i--) begin
      go[i] = !vld_r[i] || go[i+1];
    end
  end

  assign in_stall = !go[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (go[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int i = 1; i < N_ST; i++) begin
        if (go[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  // hue reduction, sector and ramp slope k = 60 - |(h mod 120) - 60|
  always_comb begin
    h_red = (in_word.hue >= HUE_WRAP) ? in_word.hue - HUE_WRAP : in_word.hue;
    if (h_red < HUE_60) begin
      sec_nxt = SEC_R_G;
    end else if (h_red < HUE_120) begin
      sec_nxt = SEC_G_R;
    end else if (h_red < HUE_180) begin
      sec_nxt = SEC_G_B;
    end else if (h_red < HUE_240) begin
      sec_nxt = SEC_B_G;
    end else if (h_red < HUE_300) begin
      sec_nxt = SEC_B_R;
    end else begin
      sec_nxt = SEC_R_B;
    end
    if (h_red >= HUE_240) begin
      hm = h_red - HUE_240;
    end else if (h_red >= HUE_120) begin
      hm = h_red - HUE_120;
    end else begin
      hm = h_red;
    end
    k_w   = (hm >= HUE_60) ? 7'(HUE_120 - hm) : hm[6:0];
    k_nxt = k_w[5:0];
  end

  always_ff @(posedge clk) begin
    if (go[0]) begin
      vs_r   <= 16'(in_word.brightness) * 16'(in_word.saturation);
      v1_r   <= in_word.brightness;
      sec1_r <= sec_nxt;
      k1_r   <= k_nxt;
    end
  end

  // v*(255-s) = 255v - vs, never negative
  assign vns = {v1_r, 8'd0} - 16'(v1_r) - vs_r;

  always_ff @(posedge clk) begin
    if (go[1]) begin
      base_r   <= NUM_W'(vns) * NUM_W'(60);
      chroma_r <= NUM_W'(vs_r) * NUM_W'(60);
      ramp_r   <= NUM_W'(vs_r) * NUM_W'(k1_r);
      sec2_r   <= sec1_r;
    end
  end

  // channel order: 0 red, 1 green, 2 blue
  always_comb begin
    num_nxt[0] = base_r;
    num_nxt[1] = base_r;
    num_nxt[2] = base_r;
    case (sec2_r)
      SEC_R_G: begin
        num_nxt[0] = base_r + chroma_r;
        num_nxt[1] = base_r + ramp_r;
      end
      SEC_G_R: begin
        num_nxt[0] = base_r + ramp_r;
        num_nxt[1] = base_r + chroma_r;
      end
      SEC_G_B: begin
        num_nxt[1] = base_r + chroma_r;
        num_nxt[2] = base_r + ramp_r;
      end
      SEC_B_G: begin
        num_nxt[1] = base_r + ramp_r;
        num_nxt[2] = base_r + chroma_r;
      end
      SEC_B_R: begin
        num_nxt[0] = base_r + ramp_r;
        num_nxt[2] = base_r + chroma_r;
      end
      default: begin
        num_nxt[0] = base_r + chroma_r;
        num_nxt[2] = base_r + ramp_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (go[2]) begin
      for (int c = 0; c < 3; c++) begin
        num_r[c] <= num_nxt[c];
      end
    end
  end

  // divide by 15300 per channel
  for (genvar c = 0; c < 3; c++) begin : g_div
    hsvrgb_div u_div (
      .clk  (clk),
      .en_a (go[3]),
      .en_b (go[4]),
      .num  (num_r[c]),
      .quo  (quo[c])
    );
  end

  assign out_valid          = vld_r[N_ST-1];
  assign out_word.red_out   = quo[0];
  assign out_word.green_out = quo[1];
  assign out_word.blue_out  = quo[2];

endmodule

[sv/hsvrgb_chk.sv]
module hsvrgb_chk
  import hsvrgb_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input hsv_word_t in_word,
  input logic      out_valid,
  input logic      out_stall,
  input rgb_word_t out_word
);

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled output word changed");

  // the pipe only backs up when the output is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("in_stall without a blocked output");

  // an accepted pixel reaches out_valid while out_stall stays low
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc ##1 !out_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall
      |=> out_valid)
    else $error("accepted pixel did not arrive in five cycles");

endmodule

bind hsv_to_rgb_convert_core hsvrgb_chk u_hsvrgb_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
